[src/lse_pkg.sv]
package lse_pkg;

  // default header geometry
  localparam int LEN_BYTES_DEF       = 8;
  localparam int LEN_BITS_DEF        = 32;
  localparam int PACK_FIELD_BITS_DEF = 4;

  // fixed widths
  localparam int LEN_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int BPC_W   = 4;
  localparam int ABITS_W = 3;
  localparam logic [BPC_W-1:0] BPC_MAX = 4'd8;
  localparam logic [BPC_W-1:0] BPC_MIN = 4'd1;

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_BPC  = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } lse_phase_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_DATA  = 1'b1
  } lse_kind_t;

  // start carries the message length, data carries carrier byte and bit count
  typedef struct packed {
    lse_kind_t         kind;
    logic [LEN_W-1:0]  data;
    logic [BPC_W-1:0]  nbits;
  } lse_entry_t;

  typedef struct packed {
    logic       valid;
    lse_entry_t entry;
  } lse_cmd_t;

endpackage

[src/lse_front.sv]
module lse_front import lse_pkg::*; #(
  parameter int LEN_BYTES       = LEN_BYTES_DEF,
  parameter int LEN_BITS        = LEN_BITS_DEF,
  parameter int PACK_FIELD_BITS = PACK_FIELD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_carrier_byte,
  input  logic              in_new_message,
  input  logic              q_full,
  output lse_cmd_t          push
);

  localparam int BPH      = LEN_BITS / LEN_BYTES;
  localparam int HDR_TAKE = (BPH > BYTE_W) ? BYTE_W : BPH;
  localparam logic [BYTE_W-1:0] HDR_MASK = BYTE_W'((16'd1 << HDR_TAKE) - 16'd1);
  localparam int HC_W  = $clog2(LEN_BYTES + 1);
  localparam int POS_W = $clog2(LEN_BITS + 1);

  lse_phase_t         phase_r, phase_nxt, ph_eff;
  logic [HC_W-1:0]    hc_r, hc_nxt, hc_eff, hc_inc;
  logic [POS_W-1:0]   pos_r, pos_nxt, pos_eff;
  logic [LEN_W-1:0]   len_r, len_nxt, len_eff, len_acc;
  logic [BPC_W-1:0]   bpc_r, bpc_nxt, bpc_raw;
  logic [2*LEN_W-1:0] hdr_wide;
  logic               in_fire;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  // phase and header registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      hc_r    <= '0;
      pos_r   <= '0;
      len_r   <= '0;
      bpc_r   <= BPC_MIN;
    end else begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      bpc_r   <= bpc_nxt;
    end
  end

  // new message restarts header parsing with this byte
  assign ph_eff  = in_new_message ? PH_LEN : phase_r;
  assign hc_eff  = in_new_message ? '0 : hc_r;
  assign pos_eff = in_new_message ? '0 : pos_r;
  assign len_eff = in_new_message ? '0 : len_r;

  assign hc_inc   = hc_eff + HC_W'(1);
  assign hdr_wide = (2*LEN_W)'(in_carrier_byte & HDR_MASK) << pos_eff;
  assign len_acc  = len_eff | hdr_wide[LEN_W-1:0];
  assign bpc_raw  = BPC_W'(in_carrier_byte[PACK_FIELD_BITS-1:0]);

  // classify each transfer
  always_comb begin
    phase_nxt   = phase_r;
    hc_nxt      = hc_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    bpc_nxt     = bpc_r;
    push.valid  = 1'b0;
    push.entry  = '{kind: KIND_DATA,
                   data: LEN_W'(in_carrier_byte),
                   nbits: bpc_r};
    if (in_fire) begin
      phase_nxt = ph_eff;
      hc_nxt    = hc_eff;
      pos_nxt   = pos_eff;
      len_nxt   = len_eff;
      case (ph_eff)
        PH_LEN: begin
          hc_nxt  = hc_inc;
          pos_nxt = pos_eff + POS_W'(BPH);
          len_nxt = len_acc;
          if (hc_inc == HC_W'(LEN_BYTES)) begin
            phase_nxt = PH_BPC;
            // a negative length counts as zero
            if (len_acc[LEN_W-1]) begin
              len_nxt = '0;
            end
          end
        end
        PH_BPC: begin
          if (bpc_raw < BPC_MIN) begin
            bpc_nxt = BPC_MIN;
          end else if (bpc_raw > BPC_MAX) begin
            bpc_nxt = BPC_MAX;
          end else begin
            bpc_nxt = bpc_raw;
          end
          push.valid       = 1'b1;
          push.entry.kind  = KIND_START;
          push.entry.data  = len_eff;
          phase_nxt        = (len_eff == '0) ? PH_DONE : PH_DATA;
        end
        PH_DATA: begin
          push.valid = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[src/lse_fifo.sv]
module lse_fifo import lse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lse_cmd_t   push,
  output logic       full,
  input  logic       pop,
  output lse_cmd_t   head
);

  lse_entry_t         mem [Q_DEPTH];
  lse_entry_t         head_r;
  logic               head_v_r;
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               do_pop, head_free, mem_empty;
  logic               load_mem, load_push, write_mem;

  // count_r holds every entry, the head register included
  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head.valid = head_v_r;
  assign head.entry = head_r;
  assign do_pop     = pop && head_v_r;
  assign head_free  = !head_v_r || do_pop;
  assign mem_empty  = (count_r == Q_CNT_W'(head_v_r));
  assign load_mem   = head_free && !mem_empty;
  assign load_push  = head_free && mem_empty && push.valid;
  assign write_mem  = push.valid && !load_push;

  // entry storage and registered head
  always_ff @(posedge clk) begin
    if (write_mem) begin
      mem[wr_ptr_r] <= push.entry;
    end
    if (load_mem) begin
      head_r <= mem[rd_ptr_r];
    end else if (load_push) begin
      head_r <= push.entry;
    end
  end

  // pointers, head flag and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      head_v_r <= 1'b0;
    end else begin
      if (write_mem) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (load_mem) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      head_v_r <= (head_v_r && !do_pop) || load_mem || load_push;
      count_r  <= count_r + Q_CNT_W'(push.valid) - Q_CNT_W'(do_pop);
    end
  end

  // never written while full, unless the head pops in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !do_pop |-> !push.valid)
    else $error("queue written while full");

endmodule

[src/lse_back.sv]
module lse_back import lse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  lse_cmd_t          head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_message_byte,
  output logic              out_last_byte
);

  logic                busy_r, busy_nxt;
  logic [BYTE_W-1:0]   sh_r, sh_nxt;
  logic [BPC_W-1:0]    rem_r, rem_nxt;
  logic [BYTE_W-1:0]   accum_r, accum_nxt, acc_set;
  logic [ABITS_W-1:0]  abits_r, abits_nxt;
  logic [LEN_W-1:0]    emitted_r, emitted_nxt, emit_cnt;
  logic [LEN_W-1:0]    length_r, length_nxt;
  logic                done_r, done_nxt;
  logic                ov_r, ov_nxt;
  logic [BYTE_W-1:0]   ob_r, ob_nxt;
  logic                ol_r, ol_nxt;
  logic                can_emit, is_last;

  assign out_valid        = ov_r;
  assign out_message_byte = ob_r;
  assign out_last_byte    = ol_r;

  assign can_emit = !ov_r || out_ready;
  assign acc_set  = accum_r | (BYTE_W'(sh_r[0]) << abits_r);
  assign emit_cnt = emitted_r + LEN_W'(1);
  assign is_last  = (emit_cnt >= length_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rem_r     <= '0;
      accum_r   <= '0;
      abits_r   <= '0;
      emitted_r <= '0;
      length_r  <= '0;
      done_r    <= 1'b1;
      ov_r      <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      rem_r     <= rem_nxt;
      accum_r   <= accum_nxt;
      abits_r   <= abits_nxt;
      emitted_r <= emitted_nxt;
      length_r  <= length_nxt;
      done_r    <= done_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
  end

  // one carrier bit per cycle into the byte accumulator; a full output holds a byte's last bit
  always_comb begin
    busy_nxt    = busy_r;
    sh_nxt      = sh_r;
    rem_nxt     = rem_r;
    accum_nxt   = accum_r;
    abits_nxt   = abits_r;
    emitted_nxt = emitted_r;
    length_nxt  = length_r;
    done_nxt    = done_r;
    ov_nxt      = ov_r && !out_ready;
    ob_nxt      = ob_r;
    ol_nxt      = ol_r;
    pop         = 1'b0;
    if (busy_r) begin
      if (abits_r != ABITS_W'(BYTE_W - 1)) begin
        accum_nxt = acc_set;
        abits_nxt = abits_r + ABITS_W'(1);
        sh_nxt    = sh_r >> 1;
        rem_nxt   = rem_r - BPC_W'(1);
        busy_nxt  = (rem_r != BPC_W'(1));
      end else if (can_emit) begin
        // byte complete, hand it to the output register
        ov_nxt      = 1'b1;
        ob_nxt      = acc_set;
        ol_nxt      = is_last;
        emitted_nxt = emit_cnt;
        accum_nxt   = '0;
        abits_nxt   = '0;
        sh_nxt      = sh_r >> 1;
        rem_nxt     = rem_r - BPC_W'(1);
        if (is_last) begin
          done_nxt = 1'b1;
          busy_nxt = 1'b0;
        end else begin
          busy_nxt = (rem_r != BPC_W'(1));
        end
      end
    end else if (head.valid) begin
      pop = 1'b1;
      case (head.entry.kind)
        KIND_START: begin
          length_nxt  = head.entry.data;
          emitted_nxt = '0;
          accum_nxt   = '0;
          abits_nxt   = '0;
          done_nxt    = (head.entry.data == '0);
        end
        KIND_DATA: begin
          // carriers after the final byte are dropped
          if (!done_r) begin
            busy_nxt = 1'b1;
            sh_nxt   = head.entry.data[BYTE_W-1:0];
            rem_nxt  = head.entry.nbits;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a live message has bytes left to send
  a_live_not_over: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> emitted_r < length_r)
    else $error("byte count reached length without done");

  // working on a carrier only within a live message
  a_busy_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r && rem_r != '0)
    else $error("busy with no bits left or after done");

  // a completed byte is never dropped under stall
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && abits_r == ABITS_W'(BYTE_W - 1) && !can_emit |=> busy_r && $stable(accum_r))
    else $error("completed byte lost while output stalled");

endmodule

[src/lsb_stego_extractor.sv]
// channel  | ports                                            | direction
// ---------+--------------------------------------------------+----------
// input    | in_valid, in_ready, in_carrier_byte, in_new_message | in
// result   | out_valid, out_ready, out_message_byte, out_last_byte | out
//
// length carriers are taken by the front part, one per cycle while the queue
// is not full, and need no back work; the bit-count carrier also queues a start
// command that the back packer pops without bit work. a data carrier is loaded
// from the queue by the back packer, then takes one bit per cycle (1 to 8 bits).
// a four-entry command queue lets the front keep taking carriers meanwhile, until it fills.
// synchronous reset returns to length-header parsing; no clearing pass.
// a full output register stalls the packer on the bit that completes a byte.
module lsb_stego_extractor import lse_pkg::*; #(
  parameter int LEN_BYTES       = LEN_BYTES_DEF,
  parameter int LEN_BITS        = LEN_BITS_DEF,
  parameter int PACK_FIELD_BITS = PACK_FIELD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_carrier_byte,
  input  logic              in_new_message,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_message_byte,
  output logic              out_last_byte
);

  lse_cmd_t push, head;
  logic     q_full, pop;

  // header parsing and carrier classification
  lse_front #(
    .LEN_BYTES       (LEN_BYTES),
    .LEN_BITS        (LEN_BITS),
    .PACK_FIELD_BITS (PACK_FIELD_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_carrier_byte (in_carrier_byte),
    .in_new_message  (in_new_message),
    .q_full          (q_full),
    .push            (push)
  );

  // command queue
  lse_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  // bit-serial byte packer
  lse_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_message_byte (out_message_byte),
    .out_last_byte    (out_last_byte)
  );

endmodule

[tb/tb_top.sv]
module tb_top;
  import lse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR_BITS      = LEN_BITS_DEF / LEN_BYTES_DEF;
  localparam int RANDOM_ITEMS  = 850;
  localparam int QUIET_FIRST   = 300;
  localparam int QUIET_LAST    = 450;
  localparam int DRAIN_CYCLES  = 120;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DIR_ROWS      = 23;

  typedef struct packed {
    logic [BYTE_W-1:0] msg_byte;
    logic              last;
  } msg_result_t;

  // one directed carrier, with its result typed in where it is obvious
  typedef struct packed {
    logic [BYTE_W-1:0] carrier;
    logic              new_msg;
    logic              typed;
    logic              has_res;
    msg_result_t       res;
  } carrier_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_carrier_byte;
  logic              in_new_message;
  logic              out_valid;
  logic              out_ready;
  logic [BYTE_W-1:0] out_message_byte;
  logic              out_last_byte;

  // expectation attached to the carrier currently offered
  logic              row_typed;
  logic              row_has_res;
  msg_result_t       row_res;

  msg_result_t       expected_bytes[$];
  int unsigned       fail_count;
  int unsigned       items_sent;
  int unsigned       cycle_count;
  bit                quiet;

  // predicted extractor state
  lse_phase_t        parse_phase;
  int unsigned       hdr_count;
  logic [LEN_W-1:0]  msg_len;
  int unsigned       bits_per_carrier;
  logic [BYTE_W-1:0] accum;
  int unsigned       accum_n;
  logic [LEN_W-1:0]  emitted;

  // directed rows: message of length one at eight bits per carrier, then a
  // negative length that counts as zero, then a restart cut off mid-header
  carrier_row_t dir_rows [DIR_ROWS] = '{
    '{8'hF1, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hA0, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'h50, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'h00, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'h00, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'h00, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'h00, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'h70, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'h3F, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hA5, 1'b0, 1'b1, 1'b1, '{8'hA5, 1'b1}},
    '{8'hFF, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'h00, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'h02, 1'b1, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{8'h13, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0}}
  };

  lsb_stego_extractor DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_carrier_byte  (in_carrier_byte),
    .in_new_message   (in_new_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_message_byte (out_message_byte),
    .out_last_byte    (out_last_byte)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void clear_extractor();
    parse_phase      = PH_LEN;
    hdr_count        = 0;
    msg_len          = '0;
    bits_per_carrier = 1;
    accum            = '0;
    accum_n          = 0;
    emitted          = '0;
  endfunction

  // advance the predicted state by one carrier, return 1 when a byte completes
  function automatic bit extract_carrier(input logic [BYTE_W-1:0] carrier,
                                         input logic new_msg,
                                         output msg_result_t res);
    int unsigned pos;
    int unsigned field;
    bit          produced;
    produced = 1'b0;
    res      = '0;
    if (new_msg) clear_extractor();
    case (parse_phase)
      PH_LEN: begin
        for (int i = 0; i < HDR_BITS; i++) begin
          pos = hdr_count * HDR_BITS + i;
          if (i < BYTE_W && pos < LEN_W && carrier[i]) msg_len[pos] = 1'b1;
        end
        hdr_count++;
        if (hdr_count >= LEN_BYTES_DEF) begin
          if (msg_len[LEN_W-1]) msg_len = '0;
          parse_phase = PH_BPC;
        end
      end
      PH_BPC: begin
        field = carrier & ((1 << PACK_FIELD_BITS_DEF) - 1);
        if (field < BPC_MIN) field = BPC_MIN;
        if (field > BPC_MAX) field = BPC_MAX;
        bits_per_carrier = field;
        parse_phase = (msg_len == '0) ? PH_DONE : PH_DATA;
      end
      PH_DATA: begin
        for (int i = 0; i < BYTE_W; i++) begin
          if (i >= bits_per_carrier) break;
          accum[accum_n] = carrier[i];
          accum_n++;
          if (accum_n == BYTE_W) begin
            emitted++;
            res.msg_byte = accum;
            res.last     = (emitted >= msg_len);
            produced     = 1'b1;
            accum        = '0;
            accum_n      = 0;
            if (res.last) begin
              parse_phase = PH_DONE;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return produced;
  endfunction

  // result check first, then prediction for the carrier taken at this edge
  always @(posedge clk) begin
    msg_result_t got;
    msg_result_t want;
    msg_result_t pred;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_message_byte, out_last_byte};
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual byte %02h last %0b",
                   $time, got.msg_byte, got.last);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (got.msg_byte !== want.msg_byte) begin
            $display("%0t: message_byte mismatch, expected %02h, actual %02h",
                     $time, want.msg_byte, got.msg_byte);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                     $time, want.last, got.last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (extract_carrier(in_carrier_byte, in_new_message, pred) && !row_typed)
          expected_bytes.push_back(pred);
        if (row_typed && row_has_res) expected_bytes.push_back(row_res);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 13);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // offer one carrier, entered and left at a falling edge
  task automatic send_carrier(input logic [BYTE_W-1:0] carrier, input logic new_msg,
                              input logic typed, input logic has_res,
                              input msg_result_t res);
    if (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_carrier_byte <= carrier;
    in_new_message  <= new_msg;
    row_typed       <= typed;
    row_has_res     <= has_res;
    row_res         <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // one message: header, bit count, data; sometimes cut short
  task automatic send_message();
    logic [LEN_W-1:0]  len;
    logic [3:0]        bpc_field;
    logic [BYTE_W-1:0] carrier;
    int unsigned       eff_bpc;
    int unsigned       n_data;
    int                cut;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 6)       len = '0;
    else if (pick < 12) len = {1'b1, 31'($urandom)};
    else if (pick < 17) len = $urandom_range(13, 40);
    else                len = $urandom_range(1, 12);
    bpc_field = 4'($urandom_range(0, 15));
    eff_bpc = (bpc_field == 0) ? 1 : ((bpc_field > 8) ? 8 : bpc_field);
    if (eff_bpc < 4 && len > 12 && !len[LEN_W-1]) len = len % 12 + 1;
    if (len == '0 || len[LEN_W-1]) n_data = $urandom_range(0, 3);
    else n_data = (len * 8 + eff_bpc - 1) / eff_bpc + $urandom_range(0, 3);
    cut = ($urandom_range(0, 99) < 10) ? int'($urandom_range(1, 8 + n_data)) : -1;
    for (int b = 0; b < 9 + n_data; b++) begin
      if (b == cut) break;
      if (b < 8)       carrier = {4'($urandom), len[4*b +: 4]};
      else if (b == 8) carrier = {4'($urandom), bpc_field};
      else             carrier = 8'($urandom);
      send_carrier(carrier, b == 0, 1'b0, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned target;
    in_valid        = 1'b0;
    in_carrier_byte = '0;
    in_new_message  = 1'b0;
    out_ready       = 1'b0;
    row_typed       = 1'b0;
    row_has_res     = 1'b0;
    row_res         = '0;
    fail_count      = 0;
    items_sent      = 0;
    cycle_count     = 0;
    quiet           = 1'b0;
    clear_extractor();
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[r])
      send_carrier(dir_rows[r].carrier, dir_rows[r].new_msg, dir_rows[r].typed,
                   dir_rows[r].has_res, dir_rows[r].res);

    // random messages mixed with noise bursts
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      quiet = (items_sent >= target - RANDOM_ITEMS + QUIET_FIRST) &&
              (items_sent < target - RANDOM_ITEMS + QUIET_LAST);
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 6))
          send_carrier(8'($urandom), $urandom_range(0, 99) < 20, 1'b0, 1'b0, '0);
      end else begin
        send_message();
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // drain outstanding results, then watch for strays
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
